// ----- src/tse_pkg.sv -----
// Shared types, constants and helpers for the TLS server-name extractor.
// No dependencies; imported by every module of the block.
package tse_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int OFFSET_W        = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LEN_W           = 18;
    localparam int MIN_FRAME_BYTES = 99;
    localparam int QUEUE_DEPTH     = 4;
    localparam int HIST_DEPTH      = 12;

    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0]  NAME_TYPE_HOST  = 8'h00;
    localparam logic [15:0] RANDOM_SKIP     = 16'd34;
    localparam logic [23:0] MIN_HELLO_LEN   = 24'd35;

    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_SHORT         = 4'd1;
    localparam logic [3:0] ST_NOT_IPV4      = 4'd2;
    localparam logic [3:0] ST_NOT_TCP       = 4'd3;
    localparam logic [3:0] ST_PORT          = 4'd4;
    localparam logic [3:0] ST_NO_RECORD     = 4'd5;
    localparam logic [3:0] ST_NOT_HANDSHAKE = 4'd6;
    localparam logic [3:0] ST_TRUNCATED     = 4'd7;
    localparam logic [3:0] ST_NOT_HELLO     = 4'd8;
    localparam logic [3:0] ST_MALFORMED     = 4'd9;
    localparam logic [3:0] ST_NO_SNI        = 4'd10;

    typedef enum logic [4:0] {
        PH_ETH, PH_R0, PH_R1, PH_R2, PH_R3, PH_R4, PH_HS0, PH_HS1, PH_HS2, PH_HS3,
        PH_SKIP, PH_SID, PH_CS_HI, PH_CS_LO, PH_COMP, PH_EXT_HI, PH_EXT_LO,
        PH_XT0, PH_XT1, PH_XT2, PH_XT3, PH_S0, PH_S1, PH_S2, PH_S3, PH_S4,
        PH_NAME, PH_FOUND, PH_STOP
    } t_phase;

    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  name_byte;
        logic [3:0]  status;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] record_version;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [47:0] source_mac;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic name_v;
        logic verdict_v;
    } t_push;

    function automatic logic [3:0] merge_fail(input logic [3:0] cur, input logic [3:0] code);
        return (cur == ST_OK || code < cur) ? code : cur;
    endfunction

    function automatic logic watched_port(input logic [15:0] p);
        return p == 16'd443 || p == 16'd8443 || p == 16'd993 ||
               p == 16'd995 || p == 16'd465 || p == 16'd587;
    endfunction

endpackage

// ----- src/tse_parser.sv -----
// Per-byte frame parser: header capture, TLS record and ClientHello walk, verdict.
// Depends on tse_pkg.
module tse_parser
    import tse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic [7:0] i_byte,
    input  logic    i_end,
    output t_push   o_push,
    output t_result o_name_res,
    output t_result o_verdict_res
);

    logic [OFFSET_W-1:0] r_offset, n_offset;
    t_phase      r_phase, n_phase, r_after, n_after;
    logic [15:0] r_count, n_count;
    logic [15:0] r_rec_len, n_rec_len;
    logic [23:0] r_hello_end, n_hello_end;
    logic [23:0] r_ext_end, n_ext_end;
    logic [23:0] r_hello_pos, n_hello_pos;
    logic [3:0]  r_ihl, n_ihl, r_doff, n_doff;
    logic [15:0] r_shift, n_shift;
    logic [47:0] r_mac, n_mac;
    logic [31:0] r_sip, n_sip, r_dip, n_dip;
    logic [15:0] r_sport, n_sport, r_dport, n_dport, r_version, n_version;
    logic [3:0]  r_fail, n_fail;
    logic        r_content_bad, n_content_bad, r_ext_sni, n_ext_sni;
    logic [7:0]  r_hist [HIST_DEPTH];
    logic [7:0]  n_hist [HIST_DEPTH];

    always_comb begin
        logic [OFFSET_W-1:0] o;
        logic                in_range;
        logic [3:0]          ihl_eff;
        logic [7:0]          tcp_base;
        logic [7:0]          tls_start;
        logic [OFFSET_W-1:0] rel;
        logic                hdr_done;
        logic [7:0]          win [HIST_DEPTH + 1];
        logic [7:0]          tb  [HIST_DEPTH + 1];
        logic [23:0]         hp;
        logic [15:0]         t;
        logic [24:0]         sum;
        logic                do_go;
        t_phase              go_to;
        logic [LEN_W-1:0]    len;
        logic [LEN_W-1:0]    rec_start;
        logic [3:0]          st;

        n_offset = r_offset;   n_phase = r_phase;       n_after = r_after;
        n_count = r_count;     n_rec_len = r_rec_len;   n_hello_end = r_hello_end;
        n_ext_end = r_ext_end; n_hello_pos = r_hello_pos;
        n_ihl = r_ihl;         n_doff = r_doff;         n_shift = r_shift;
        n_mac = r_mac;         n_sip = r_sip;           n_dip = r_dip;
        n_sport = r_sport;     n_dport = r_dport;       n_version = r_version;
        n_fail = r_fail;       n_content_bad = r_content_bad; n_ext_sni = r_ext_sni;
        n_hist = r_hist;
        o_push = '0;
        o_name_res = '0;
        o_verdict_res = '0;
        do_go = 1'b0;
        go_to = PH_ETH;
        hdr_done = 1'b0;
        t = '0;
        sum = '0;
        rel = '0;

        o = r_offset;
        in_range = r_offset < OFFSET_W'(MAX_FRAME_BYTES);
        ihl_eff = (o == OFFSET_W'(14)) ? i_byte[3:0] : r_ihl;
        tcp_base = 8'd14 + {2'b00, ihl_eff, 2'b00};
        tls_start = 8'd14 + {2'b00, r_ihl, 2'b00} + {2'b00, r_doff, 2'b00};
        hp = (r_phase inside {[PH_SKIP:PH_NAME]}) ? r_hello_pos + 24'd1 : r_hello_pos;

        // look-back window: age 0 is the current byte
        win[0] = i_byte;
        for (int k = 1; k <= HIST_DEPTH; k++) win[k] = r_hist[k-1];
        for (int j = 0; j <= HIST_DEPTH; j++) tb[j] = '0;
        case (i_byte[7:4])
            4'd0: for (int j = 0; j <= 12; j++) tb[j] = win[12-j];
            4'd1: for (int j = 0; j <= 8; j++) tb[j] = win[8-j];
            4'd2: for (int j = 0; j <= 4; j++) tb[j] = win[4-j];
            4'd3: tb[0] = win[0];
            default: ;
        endcase

        if (in_range) begin
            n_offset = r_offset + OFFSET_W'(1);
            n_hist[0] = i_byte;
            for (int k = 1; k < HIST_DEPTH; k++) n_hist[k] = r_hist[k-1];

            if (r_phase == PH_ETH) begin
                if (o >= OFFSET_W'(6) && o <= OFFSET_W'(11)) n_mac = {r_mac[39:0], i_byte};
                if (o == OFFSET_W'(12)) n_shift = {8'h00, i_byte};
                if (o == OFFSET_W'(13) && {r_shift[7:0], i_byte} != ETHERTYPE_IPV4)
                    n_fail = merge_fail(n_fail, ST_NOT_IPV4);
                if (o == OFFSET_W'(14)) n_ihl = i_byte[3:0];
                if (o == OFFSET_W'(23) && i_byte != PROTO_TCP)
                    n_fail = merge_fail(n_fail, ST_NOT_TCP);
                if (o >= OFFSET_W'(26) && o <= OFFSET_W'(29)) n_sip = {r_sip[23:0], i_byte};
                if (o >= OFFSET_W'(30) && o <= OFFSET_W'(33)) n_dip = {r_dip[23:0], i_byte};
                if (o >= OFFSET_W'(14) && o >= OFFSET_W'(tcp_base)) begin
                    rel = o - OFFSET_W'(tcp_base);
                    if (rel <= OFFSET_W'(1)) n_sport = {r_sport[7:0], i_byte};
                    if (rel == OFFSET_W'(2) || rel == OFFSET_W'(3))
                        n_dport = {r_dport[7:0], i_byte};
                    if (rel == OFFSET_W'(3) && !watched_port({r_dport[7:0], i_byte}))
                        n_fail = merge_fail(n_fail, ST_PORT);
                    if (rel == OFFSET_W'(12)) hdr_done = 1'b1;
                end

                // data-offset byte: replay record bytes that already went by
                if (hdr_done) begin
                    n_doff = i_byte[7:4];
                    if (n_fail != ST_OK) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_phase = PH_R0;
                        if (i_byte[7:4] <= 4'd3) begin
                            n_content_bad = tb[0] != REC_HANDSHAKE;
                            n_phase = PH_R1;
                        end
                        if (i_byte[7:4] <= 4'd2) begin
                            n_version = {tb[1], tb[2]};
                            n_shift = {8'h00, tb[3]};
                            n_rec_len = {tb[3], tb[4]};
                            if (n_content_bad) n_phase = PH_STOP;
                            else if (n_rec_len < 16'd4) begin
                                n_fail = merge_fail(n_fail, ST_NOT_HELLO);
                                n_phase = PH_STOP;
                            end else n_phase = PH_HS0;
                        end
                        if (i_byte[7:4] <= 4'd1 && n_phase == PH_HS0) begin
                            if (tb[5] != HS_CLIENT_HELLO) begin
                                n_fail = merge_fail(n_fail, ST_NOT_HELLO);
                                n_phase = PH_STOP;
                            end else begin
                                n_shift = {tb[6], tb[7]};
                                n_hello_end = {tb[6], tb[7], tb[8]};
                                if (n_hello_end < MIN_HELLO_LEN) begin
                                    n_fail = merge_fail(n_fail, ST_MALFORMED);
                                    n_phase = PH_STOP;
                                end else begin
                                    n_hello_pos = '0;
                                    n_count = RANDOM_SKIP;
                                    n_after = PH_SID;
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                        if (i_byte[7:4] == 4'd0 && n_phase == PH_SKIP) begin
                            n_hello_pos = 24'd4;
                            n_count = RANDOM_SKIP - 16'd4;
                        end
                    end
                end
            end else if (r_phase != PH_STOP && r_phase != PH_FOUND &&
                         o >= OFFSET_W'(tls_start)) begin
                n_hello_pos = hp;
                case (r_phase)
                    PH_R0: begin
                        n_content_bad = i_byte != REC_HANDSHAKE;
                        n_phase = PH_R1;
                    end
                    PH_R1: begin n_version = {i_byte, 8'h00}; n_phase = PH_R2; end
                    PH_R2: begin n_version = {r_version[15:8], i_byte}; n_phase = PH_R3; end
                    PH_R3: begin n_shift = {8'h00, i_byte}; n_phase = PH_R4; end
                    PH_R4: begin
                        n_rec_len = {r_shift[7:0], i_byte};
                        if (r_content_bad) n_phase = PH_STOP;
                        else if (n_rec_len < 16'd4) begin
                            n_fail = merge_fail(n_fail, ST_NOT_HELLO);
                            n_phase = PH_STOP;
                        end else n_phase = PH_HS0;
                    end
                    PH_HS0: begin
                        if (i_byte != HS_CLIENT_HELLO) begin
                            n_fail = merge_fail(n_fail, ST_NOT_HELLO);
                            n_phase = PH_STOP;
                        end else n_phase = PH_HS1;
                    end
                    PH_HS1: begin n_shift = {8'h00, i_byte}; n_phase = PH_HS2; end
                    PH_HS2: begin n_shift = {r_shift[7:0], i_byte}; n_phase = PH_HS3; end
                    PH_HS3: begin
                        n_hello_end = {r_shift, i_byte};
                        if (n_hello_end < MIN_HELLO_LEN) begin
                            n_fail = merge_fail(n_fail, ST_MALFORMED);
                            n_phase = PH_STOP;
                        end else begin
                            n_hello_pos = '0;
                            n_count = RANDOM_SKIP;
                            n_after = PH_SID;
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        n_count = r_count - 16'd1;
                        if (n_count == '0) begin do_go = 1'b1; go_to = r_after; end
                    end
                    PH_SID: begin
                        sum = {1'b0, hp} + 25'(i_byte) + 25'd2;
                        if (sum > {1'b0, r_hello_end}) begin
                            n_fail = merge_fail(n_fail, ST_MALFORMED);
                            n_phase = PH_STOP;
                        end else if (i_byte == 8'h00) begin
                            do_go = 1'b1; go_to = PH_CS_HI;
                        end else begin
                            n_count = {8'h00, i_byte}; n_after = PH_CS_HI; n_phase = PH_SKIP;
                        end
                    end
                    PH_CS_HI: begin n_shift = {8'h00, i_byte}; n_phase = PH_CS_LO; end
                    PH_CS_LO: begin
                        t = {r_shift[7:0], i_byte};
                        sum = {1'b0, hp} + 25'(t) + 25'd1;
                        if (sum > {1'b0, r_hello_end}) begin
                            n_fail = merge_fail(n_fail, ST_MALFORMED);
                            n_phase = PH_STOP;
                        end else if (t == '0) begin
                            do_go = 1'b1; go_to = PH_COMP;
                        end else begin
                            n_count = t; n_after = PH_COMP; n_phase = PH_SKIP;
                        end
                    end
                    PH_COMP: begin
                        sum = {1'b0, hp} + 25'(i_byte) + 25'd2;
                        if (sum > {1'b0, r_hello_end}) begin
                            n_fail = merge_fail(n_fail, ST_MALFORMED);
                            n_phase = PH_STOP;
                        end else if (i_byte == 8'h00) begin
                            do_go = 1'b1; go_to = PH_EXT_HI;
                        end else begin
                            n_count = {8'h00, i_byte}; n_after = PH_EXT_HI; n_phase = PH_SKIP;
                        end
                    end
                    PH_EXT_HI: begin n_shift = {8'h00, i_byte}; n_phase = PH_EXT_LO; end
                    PH_EXT_LO: begin
                        t = {r_shift[7:0], i_byte};
                        sum = {1'b0, hp} + 25'(t);
                        if (sum > {1'b0, r_hello_end}) begin
                            n_fail = merge_fail(n_fail, ST_MALFORMED);
                            n_phase = PH_STOP;
                        end else begin
                            n_ext_end = sum[23:0];
                            do_go = 1'b1; go_to = PH_XT0;
                        end
                    end
                    PH_XT0: begin n_shift = {8'h00, i_byte}; n_phase = PH_XT1; end
                    PH_XT1: begin
                        n_ext_sni = {r_shift[7:0], i_byte} == EXT_SERVER_NAME;
                        n_phase = PH_XT2;
                    end
                    PH_XT2: begin n_shift = {8'h00, i_byte}; n_phase = PH_XT3; end
                    PH_XT3: begin
                        t = {r_shift[7:0], i_byte};
                        sum = {1'b0, hp} + 25'(t);
                        if (!r_ext_sni) begin
                            if (t == '0) begin do_go = 1'b1; go_to = PH_XT0; end
                            else begin n_count = t; n_after = PH_XT0; n_phase = PH_SKIP; end
                        end else if (t < 16'd5 || sum > {1'b0, r_ext_end}) begin
                            n_fail = merge_fail(n_fail, ST_NO_SNI);
                            n_phase = PH_STOP;
                        end else n_phase = PH_S0;
                    end
                    PH_S0: n_phase = PH_S1;
                    PH_S1: n_phase = PH_S2;
                    PH_S2: begin
                        if (i_byte != NAME_TYPE_HOST) begin
                            n_fail = merge_fail(n_fail, ST_NO_SNI);
                            n_phase = PH_STOP;
                        end else n_phase = PH_S3;
                    end
                    PH_S3: begin n_shift = {8'h00, i_byte}; n_phase = PH_S4; end
                    PH_S4: begin
                        t = {r_shift[7:0], i_byte};
                        sum = {1'b0, hp} + 25'(t);
                        if (sum > {1'b0, r_ext_end}) begin
                            n_fail = merge_fail(n_fail, ST_NO_SNI);
                            n_phase = PH_STOP;
                        end else if (t == '0) n_phase = PH_FOUND;
                        else begin n_count = t; n_phase = PH_NAME; end
                    end
                    PH_NAME: begin
                        o_push.name_v = 1'b1;
                        o_name_res.name_byte = i_byte;
                        o_name_res.last_result = !i_end;
                        n_count = r_count - 16'd1;
                        if (n_count == '0) n_phase = PH_FOUND;
                    end
                    default: ;
                endcase

                // continue with the field after a skip; extension walk checks room
                if (do_go) begin
                    if (go_to == PH_XT0) begin
                        if ({1'b0, hp} + 25'd4 <= {1'b0, n_ext_end}) n_phase = PH_XT0;
                        else begin
                            n_fail = merge_fail(n_fail, ST_NO_SNI);
                            n_phase = PH_STOP;
                        end
                    end else n_phase = go_to;
                end
            end
        end

        // verdict on the final byte, from the updated state
        len = LEN_W'(n_offset);
        rec_start = LEN_W'(8'd14 + {2'b00, n_ihl, 2'b00}) + LEN_W'({n_doff, 2'b00}) +
                    LEN_W'(5);
        if (len < LEN_W'(MIN_FRAME_BYTES)) st = ST_SHORT;
        else if (n_fail inside {[ST_NOT_IPV4:ST_PORT]}) st = n_fail;
        else if (len < rec_start) st = ST_NO_RECORD;
        else if (n_content_bad) st = ST_NOT_HANDSHAKE;
        else if (len < rec_start + LEN_W'(n_rec_len)) st = ST_TRUNCATED;
        else if (n_fail != ST_OK) st = n_fail;
        else if (n_phase == PH_FOUND) st = ST_OK;
        else st = ST_MALFORMED;

        if (i_end) begin
            o_push.verdict_v = 1'b1;
            o_verdict_res.is_verdict = 1'b1;
            o_verdict_res.status = st;
            o_verdict_res.last_result = 1'b1;
            if (st == ST_OK) begin
                o_verdict_res.source_port = n_sport;
                o_verdict_res.dest_port = n_dport;
                o_verdict_res.record_version = n_version;
                o_verdict_res.source_ip = n_sip;
                o_verdict_res.dest_ip = n_dip;
                o_verdict_res.source_mac = n_mac;
            end
            n_offset = '0;     n_phase = PH_ETH;  n_after = PH_ETH;
            n_count = '0;      n_rec_len = '0;    n_hello_end = '0;
            n_ext_end = '0;    n_hello_pos = '0;  n_ihl = '0;  n_doff = '0;
            n_shift = '0;      n_mac = '0;        n_sip = '0;  n_dip = '0;
            n_sport = '0;      n_dport = '0;      n_version = '0;
            n_fail = ST_OK;    n_content_bad = 1'b0; n_ext_sni = 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++) n_hist[k] = '0;
        end

        // results are only pushed for a taken transaction
        if (!i_valid) o_push = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;     r_phase <= PH_ETH;  r_after <= PH_ETH;
            r_count <= '0;      r_rec_len <= '0;    r_hello_end <= '0;
            r_ext_end <= '0;    r_hello_pos <= '0;  r_ihl <= '0;  r_doff <= '0;
            r_shift <= '0;      r_mac <= '0;        r_sip <= '0;  r_dip <= '0;
            r_sport <= '0;      r_dport <= '0;      r_version <= '0;
            r_fail <= ST_OK;    r_content_bad <= 1'b0; r_ext_sni <= 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++) r_hist[k] <= '0;
        end else if (i_valid) begin
            r_offset <= n_offset;   r_phase <= n_phase;     r_after <= n_after;
            r_count <= n_count;     r_rec_len <= n_rec_len; r_hello_end <= n_hello_end;
            r_ext_end <= n_ext_end; r_hello_pos <= n_hello_pos;
            r_ihl <= n_ihl;         r_doff <= n_doff;       r_shift <= n_shift;
            r_mac <= n_mac;         r_sip <= n_sip;         r_dip <= n_dip;
            r_sport <= n_sport;     r_dport <= n_dport;     r_version <= n_version;
            r_fail <= n_fail;       r_content_bad <= n_content_bad;
            r_ext_sni <= n_ext_sni;
            r_hist <= n_hist;
        end
    end

endmodule

// ----- src/tse_outq.sv -----
// Small result queue: takes up to two results a cycle, hands out one.
// Depends on tse_pkg.
module tse_outq
    import tse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  t_result i_name_res,
    input  t_result i_verdict_res,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_result            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [PTR_W:0]     r_count, n_count;
    logic               pop;
    logic [1:0]         n_push;
    t_result            first;

    assign o_room  = r_count <= (PTR_W+1)'(QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign n_push  = {1'b0, i_push.name_v} + {1'b0, i_push.verdict_v};
    assign first   = i_push.name_v ? i_name_res : i_verdict_res;

    always_comb begin
        n_wr = r_wr + PTR_W'(n_push);
        n_rd = pop ? r_rd + PTR_W'(1) : r_rd;
        n_count = r_count + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) r_mem[r_wr] <= first;
        if (n_push == 2'd2) r_mem[r_wr + PTR_W'(1)] <= i_verdict_res;
    end

endmodule

// ----- src/tls_sni_extractor.sv -----
// Top level: TLS ClientHello server-name extractor on an Ethernet byte stream.
// A name byte or a verdict is written into the registered result queue when its input byte is taken.
// Throughput: one frame byte per cycle while o_s_tready is high; the byte that ends a frame may add a verdict.
// The four-entry result queue drops o_s_tready while fewer than two entries are free.
// Reset (i_rst_n low, synchronous) returns the parser to the Ethernet header of a new
// frame and empties the result queue.
// Depends on tse_pkg, tse_parser and tse_outq.
module tls_sni_extractor
    import tse_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] frame_byte
    input  logic         i_s_tlast,   // frame_end
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [7:0] name_byte, [11:8] status, [27:12] source_port, [43:28] dest_port,
    // [59:44] record_version, [91:60] source_ip, [123:92] dest_ip,
    // [171:124] source_mac, [175:172] zero
    output logic [175:0] o_m_tdata,
    output logic         o_m_tuser,   // is_verdict
    output logic         o_m_tlast    // last_result
);

    t_push   push;
    t_result name_res, verdict_res, head;
    logic    in_accept;

    // a transaction is taken only while the queue can absorb two results
    assign in_accept = i_s_tvalid && o_s_tready;

    tse_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_accept),
        .i_byte        (i_s_tdata),
        .i_end         (i_s_tlast),
        .o_push        (push),
        .o_name_res    (name_res),
        .o_verdict_res (verdict_res)
    );

    tse_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_name_res    (name_res),
        .i_verdict_res (verdict_res),
        .o_room        (o_s_tready),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_res         (head)
    );

    assign o_m_tdata = {4'h0, head.source_mac, head.dest_ip, head.source_ip,
                        head.record_version, head.dest_port, head.source_port,
                        head.status, head.name_byte};
    assign o_m_tuser = head.is_verdict;
    assign o_m_tlast = head.last_result;

endmodule

// ----- src/tse_checker.sv -----
// Port-level checks for the server-name extractor, bound to the top level.
// Depends on tse_pkg and tls_sni_extractor.
module tse_checker
    import tse_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [175:0] o_m_tdata,
    input logic         o_m_tuser,
    input logic         o_m_tlast
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result offered right after reset");

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("verdict not marked last");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser && o_m_tdata[11:8] != ST_OK |-> o_m_tdata[175:12] == '0)
        else $error("failed verdict carries captured fields");

    a_name_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[175:8] == '0)
        else $error("name byte result carries verdict fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

endmodule

bind tls_sni_extractor tse_checker u_tse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
